// File: hdl/mi31_pkg.sv
// shared types and constants for the mersenne-31 modular inverse core
// no dependencies

package mi31_pkg;

    localparam int unsigned WIDTH = 31;
    localparam logic [WIDTH-1:0] MODULUS = 31'h7FFF_FFFF;

    typedef logic [WIDTH-1:0] word_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [0:0] {
        OP_SHIFT,
        OP_SUB
    } op_t;

endpackage

// File: hdl/mi31_if.sv
// item channel interfaces for the modular inverse core
// depends on mi31_pkg

interface mi31_req_if;
    logic             valid;
    logic             ready;
    mi31_pkg::word_t  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface mi31_rsp_if;
    logic             valid;
    logic             ready;
    mi31_pkg::word_t  inverse;
    logic             no_inverse;

    modport source (output valid, output inverse, output no_inverse, input ready);
    modport sink   (input valid, input inverse, input no_inverse, output ready);
endinterface

// File: hdl/modular_inverse_mersenne31_core.sv
// Modular inverse modulo the prime 2^31-1 by binary extended gcd. An item is taken
// when the core is idle; it then runs one reduction step per cycle through a shared
// step unit (halve an even operand, or halve the difference of two odd operands),
// at most 60 steps since the product of the two operands halves each step; the
// result then goes to the output register once that is free. A value of zero or
// the all-ones pattern has no inverse and returns 0 with no_inverse set, without
// any reduction steps. A finished result waits in an output register while the next
// item is taken.
// depends on mi31_pkg, mi31_if, mi31_step_unit

module modular_inverse_mersenne31_core
(
    input  logic             clk,
    input  logic             rst_n,
    mi31_req_if.sink         req,
    mi31_rsp_if.source       rsp
);

    mi31_pkg::state_t  state_reg, state_next;
    mi31_pkg::word_t   u_reg, u_next;
    mi31_pkg::word_t   v_reg, v_next;
    mi31_pkg::word_t   x1_reg, x1_next;
    mi31_pkg::word_t   x2_reg, x2_next;
    logic              zero_reg, zero_next;
    logic              out_valid_reg, out_valid_next;
    mi31_pkg::word_t   out_inv_reg, out_inv_next;
    logic              out_none_reg, out_none_next;

    mi31_pkg::op_t     op;
    logic              sel_v;
    mi31_pkg::word_t   p, q, xp, xq, p_new, xp_new;
    logic              slot_free;
    logic              u_one, v_one;

    mi31_step_unit u_step
    (
        .op     (op),
        .p      (p),
        .q      (q),
        .xp     (xp),
        .xq     (xq),
        .p_new  (p_new),
        .xp_new (xp_new)
    );

    assign req.ready      = (state_reg == mi31_pkg::ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.inverse    = out_inv_reg;
    assign rsp.no_inverse = out_none_reg;

    always_comb
    begin
        u_one     = (u_reg == mi31_pkg::word_t'(1));
        v_one     = (v_reg == mi31_pkg::word_t'(1));
        slot_free = !out_valid_reg || rsp.ready;

        // pick the operand to reduce
        if (u_reg[0] && v_reg[0])
        begin
            op    = mi31_pkg::OP_SUB;
            sel_v = (u_reg < v_reg);
        end
        else
        begin
            op    = mi31_pkg::OP_SHIFT;
            sel_v = u_reg[0];
        end
        p  = sel_v ? v_reg  : u_reg;
        q  = sel_v ? u_reg  : v_reg;
        xp = sel_v ? x2_reg : x1_reg;
        xq = sel_v ? x1_reg : x2_reg;

        state_next     = state_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        x1_next        = x1_reg;
        x2_next        = x2_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_inv_next   = out_inv_reg;
        out_none_next  = out_none_reg;

        unique case (state_reg)
            mi31_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    u_next     = req.value;
                    v_next     = mi31_pkg::MODULUS;
                    x1_next    = mi31_pkg::word_t'(1);
                    x2_next    = '0;
                    zero_next  = (req.value == '0) || (req.value == mi31_pkg::MODULUS);
                    state_next = mi31_pkg::ST_RUN;
                end
            end
            mi31_pkg::ST_RUN:
            begin
                if (zero_reg || u_one || v_one)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_none_next  = zero_reg;
                        if (zero_reg)
                        begin
                            out_inv_next = '0;
                        end
                        else if (u_one)
                        begin
                            out_inv_next = x1_reg;
                        end
                        else
                        begin
                            out_inv_next = x2_reg;
                        end
                        state_next = mi31_pkg::ST_IDLE;
                    end
                end
                else if (sel_v)
                begin
                    v_next  = p_new;
                    x2_next = xp_new;
                end
                else
                begin
                    u_next  = p_new;
                    x1_next = xp_new;
                end
            end
            default:
            begin
                state_next = mi31_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mi31_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg        <= u_next;
        v_reg        <= v_next;
        x1_reg       <= x1_next;
        x2_reg       <= x2_next;
        zero_reg     <= zero_next;
        out_inv_reg  <= out_inv_next;
        out_none_reg <= out_none_next;
    end

endmodule

// File: hdl/mi31_step_unit.sv
// shared step unit of the binary inversion: halving or odd-difference halving,
// with the matching coefficient update modulo 2^31-1; depends on mi31_pkg

module mi31_step_unit
(
    input  mi31_pkg::op_t    op,
    input  mi31_pkg::word_t  p,
    input  mi31_pkg::word_t  q,
    input  mi31_pkg::word_t  xp,
    input  mi31_pkg::word_t  xq,
    output mi31_pkg::word_t  p_new,
    output mi31_pkg::word_t  xp_new
);

    logic [mi31_pkg::WIDTH:0]   diff;
    logic [mi31_pkg::WIDTH:0]   xdiff;
    mi31_pkg::word_t            xsub;
    mi31_pkg::word_t            hin;
    logic [mi31_pkg::WIDTH:0]   hsum;

    always_comb
    begin
        diff  = {1'b0, p} - {1'b0, q};
        xdiff = {1'b0, xp} - {1'b0, xq};
        if (xdiff[mi31_pkg::WIDTH])
        begin
            xsub = xdiff[mi31_pkg::WIDTH-1:0] + mi31_pkg::MODULUS;
        end
        else
        begin
            xsub = xdiff[mi31_pkg::WIDTH-1:0];
        end

        case (op)
            mi31_pkg::OP_SUB:
            begin
                p_new = {1'b0, diff[mi31_pkg::WIDTH-1:1]};
                hin   = xsub;
            end
            default:
            begin
                p_new = {1'b0, p[mi31_pkg::WIDTH-1:1]};
                hin   = xp;
            end
        endcase

        // halve modulo 2^31-1: add the odd modulus first when odd
        hsum   = {1'b0, hin} + (hin[0] ? {1'b0, mi31_pkg::MODULUS} : '0);
        xp_new = hsum[mi31_pkg::WIDTH:1];
    end

endmodule

// File: tb/tb_modular_inverse_mersenne31_core.sv
`timescale 1ns / 1ps
// testbench for modular_inverse_mersenne31_core: directed table then random residues,
// every result checked in order against a typed answer or an extended euclid predictor
// depends on mi31_pkg, mi31_if and the core

module tb_modular_inverse_mersenne31_core;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_CYCLES  = 300;
    localparam int PHASE_ITEMS   = 150;
    localparam int REPORT_MAX    = 10;
    localparam int DIRECTED_ROWS = 20;

    typedef struct packed {
        mi31_pkg::word_t inverse;
        logic            no_inverse;
    } inverse_result_t;

    typedef struct packed {
        mi31_pkg::word_t value;
        logic            typed;
        mi31_pkg::word_t inverse;
        logic            no_inverse;
    } stim_row_t;

    // typed rows carry their answer, the rest go through the predictor
    stim_row_t directed [DIRECTED_ROWS] = '{
        '{31'h0000_0000, 1'b1, 31'h0000_0000, 1'b1},
        '{31'h7FFF_FFFF, 1'b1, 31'h0000_0000, 1'b1},
        '{31'h0000_0001, 1'b1, 31'h0000_0001, 1'b0},
        '{31'h7FFF_FFFE, 1'b1, 31'h7FFF_FFFE, 1'b0},
        '{31'h0000_0002, 1'b1, 31'h4000_0000, 1'b0},
        '{31'h4000_0000, 1'b1, 31'h0000_0002, 1'b0},
        '{31'h0000_0003, 1'b0, 31'h0000_0000, 1'b0},
        '{31'h0000_0004, 1'b0, 31'h0000_0000, 1'b0},
        '{31'h5555_5555, 1'b0, 31'h0000_0000, 1'b0},
        '{31'h2AAA_AAAA, 1'b0, 31'h0000_0000, 1'b0},
        '{31'h7FFF_FFFD, 1'b0, 31'h0000_0000, 1'b0},
        '{31'h3FFF_FFFF, 1'b0, 31'h0000_0000, 1'b0},
        '{31'h4000_0001, 1'b0, 31'h0000_0000, 1'b0},
        '{31'h1234_5678, 1'b0, 31'h0000_0000, 1'b0},
        '{31'h7FFF_0000, 1'b0, 31'h0000_0000, 1'b0},
        '{31'h0000_FFFF, 1'b0, 31'h0000_0000, 1'b0},
        '{31'h6DB6_DB6D, 1'b0, 31'h0000_0000, 1'b0},
        '{31'd1327217884, 1'b0, 31'h0000_0000, 1'b0},
        '{31'h0F0F_0F0F, 1'b0, 31'h0000_0000, 1'b0},
        '{31'h7FFF_FFFC, 1'b0, 31'h0000_0000, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n;

    mi31_req_if req_ch ();
    mi31_rsp_if rsp_ch ();

    modular_inverse_mersenne31_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    inverse_result_t expected_inverses [$];
    int fail_count    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_request = 0;
    int quiet_cycles  = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic inverse_result_t predict_inverse(input mi31_pkg::word_t v);
        inverse_result_t r;
        longint rem_hi, rem_lo, quo, rem_nx, coef_prev, coef_cur, coef_nx;
        r.inverse    = '0;
        r.no_inverse = 1'b1;
        if (v == '0 || v == mi31_pkg::MODULUS)
            return r;
        rem_hi    = longint'(mi31_pkg::MODULUS);
        rem_lo    = longint'(v);
        coef_prev = 0;
        coef_cur  = 1;
        while (rem_lo != 0)
        begin
            quo       = rem_hi / rem_lo;
            rem_nx    = rem_hi - quo * rem_lo;
            coef_nx   = coef_prev - quo * coef_cur;
            rem_hi    = rem_lo;
            rem_lo    = rem_nx;
            coef_prev = coef_cur;
            coef_cur  = coef_nx;
        end
        if (coef_prev < 0)
            coef_prev += longint'(mi31_pkg::MODULUS);
        r.inverse    = mi31_pkg::word_t'(coef_prev);
        r.no_inverse = 1'b0;
        return r;
    endfunction

    function automatic mi31_pkg::word_t random_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 3)
            return '0;
        if (pick < 6)
            return mi31_pkg::MODULUS;
        if (pick < 11)
            return mi31_pkg::word_t'($urandom_range(16, 1));
        if (pick < 16)
            return mi31_pkg::MODULUS - mi31_pkg::word_t'($urandom_range(16, 1));
        if (pick < 26)
            return mi31_pkg::word_t'(1) << $urandom_range(30);
        return mi31_pkg::word_t'($urandom);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic send_item(input mi31_pkg::word_t v, input logic typed,
                             input inverse_result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            req_ch.value <= mi31_pkg::word_t'($urandom);
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.value <= v;
        do @(posedge clk); while (!req_ch.ready);
        expected_inverses.push_back(typed ? want : predict_inverse(v));
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (expected_inverses.size() != 0)
            @(posedge clk);
    endtask

    // receiver side, with an optional long hold-off
    initial
    begin
        int n;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request > 0)
            begin
                n = stall_request;
                stall_request = 0;
                rsp_ch.ready <= 1'b0;
                repeat (n - 1) @(posedge clk);
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        inverse_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_inverses.size() == 0)
                note_failure($sformatf("unexpected item inverse=%0d no_inverse=%0b",
                                       rsp_ch.inverse, rsp_ch.no_inverse));
            else
            begin
                want = expected_inverses.pop_front();
                if (rsp_ch.inverse !== want.inverse)
                    note_failure($sformatf("inverse expected %0d got %0d",
                                           want.inverse, rsp_ch.inverse));
                if (rsp_ch.no_inverse !== want.no_inverse)
                    note_failure($sformatf("no_inverse expected %0b got %0b",
                                           want.no_inverse, rsp_ch.no_inverse));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.value <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 11;
        recv_idle_pct = 78;
        foreach (directed[i])
            send_item(directed[i].value, directed[i].typed,
                      '{directed[i].inverse, directed[i].no_inverse});
        repeat (PHASE_ITEMS) send_item(random_value(), 1'b0, '0);
        drain_results();

        send_idle_pct = 78;
        recv_idle_pct = 11;
        repeat (PHASE_ITEMS) send_item(random_value(), 1'b0, '0);
        drain_results();

        // long receiver hold-off while items keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = STALL_CYCLES;
        repeat (PHASE_ITEMS) send_item(random_value(), 1'b0, '0);
        drain_results();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_inverses.size() != 0)
            note_failure($sformatf("%0d items never returned", expected_inverses.size()));

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
